// ===== src/dfbs_pkg.sv =====
// Shared types and constants for the depth floor background subtraction block.
// Used by every module under src; depends on nothing else.
`timescale 1ns / 1ps

package dfbs_pkg;

	localparam int ACT_W    = 2;
	localparam int IDX_W    = 19;
	localparam int DEPTH_W  = 16;
	localparam int MARGIN_W = 10;

	localparam logic [DEPTH_W-1:0]  FAR_VALUE_RST    = 16'd10000;
	localparam logic [MARGIN_W-1:0] LEARN_MARGIN_RST = 10'd50;

	// Configuration register indexes.
	localparam logic CFG_FAR_VALUE    = 1'b0;
	localparam logic CFG_LEARN_MARGIN = 1'b1;

	typedef enum logic [ACT_W-1:0] {
		ACT_COOK  = 2'd0,
		ACT_LEARN = 2'd1,
		ACT_CLEAR = 2'd2
	} action_t;

	// One pixel moving down the pipeline, depth already substituted.
	typedef struct packed {
		action_t            action;
		logic               in_range;
		logic [IDX_W-1:0]   idx;
		logic [DEPTH_W-1:0] depth;
	} pix_t;

	typedef struct packed {
		logic [DEPTH_W-1:0] cooked_depth;
		logic [DEPTH_W-1:0] depth_out;
	} result_t;

endpackage

// ===== src/dfbs_front.sv =====
// Input stage of the floor subtraction pipeline: captures a transaction,
// substitutes the far depth for invalid samples and checks the pixel range.
// Depends on dfbs_pkg.
`timescale 1ns / 1ps

module dfbs_front #(
	parameter int unsigned PIXEL_COUNT = 307200
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            adv,
	input  logic                            in_valid,
	input  dfbs_pkg::action_t               in_action,
	input  logic [dfbs_pkg::IDX_W-1:0]      in_idx,
	input  logic [dfbs_pkg::DEPTH_W-1:0]    in_depth_raw,
	input  logic [dfbs_pkg::DEPTH_W-1:0]    far_value,
	output logic                            v_s1,
	output dfbs_pkg::pix_t                  pix_s1
);
	import dfbs_pkg::*;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pix_s1.action   <= in_action;
			pix_s1.idx      <= in_idx;
			pix_s1.in_range <= (32'(in_idx) < PIXEL_COUNT);
			pix_s1.depth    <= (in_depth_raw == '0) ? far_value : in_depth_raw;
		end
	end

endmodule

// ===== src/dfbs_floor.sv =====
// Floor store and its read-modify-write stages: memory read, forwarding of
// writes still in flight, and the cook, learn and clear decisions.
// Depends on dfbs_pkg.
`timescale 1ns / 1ps

module dfbs_floor #(
	parameter int unsigned PIXEL_COUNT = 307200
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            adv,
	input  logic                            v_s1,
	input  dfbs_pkg::pix_t                  pix_s1,
	input  logic [dfbs_pkg::DEPTH_W-1:0]    far_value,
	input  logic [dfbs_pkg::MARGIN_W-1:0]   learn_margin,
	output logic                            v_s3,
	output dfbs_pkg::result_t               res_s3
);
	import dfbs_pkg::*;

	localparam int ADDR_W = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;

	logic [DEPTH_W-1:0] mem [PIXEL_COUNT];

	logic               v_s2;
	pix_t               pix_s2;
	logic [DEPTH_W-1:0] rd_s2;
	logic               hit_q;
	logic [DEPTH_W-1:0] fwd_q;
	logic [DEPTH_W-1:0] floor_s2;

	pix_t               pix_s3;
	logic [DEPTH_W-1:0] floor_s3;
	logic               we_s3;
	logic [DEPTH_W-1:0] wdata_s3;
	logic [DEPTH_W-1:0] cooked_s3;
	logic               learn_hit;
	logic               near_hit;

	logic [ADDR_W-1:0]  raddr;
	logic [ADDR_W-1:0]  waddr;

	assign raddr = ADDR_W'(pix_s1.idx);
	assign waddr = ADDR_W'(pix_s3.idx);

	// The write from stage three and the read for stage two share an edge;
	// the read returns the old entry, so the written value is kept aside.
	always_ff @(posedge clk) begin
		if (adv) begin
			if (we_s3) begin
				mem[waddr] <= wdata_s3;
			end
			if (v_s1 && pix_s1.in_range) begin
				rd_s2 <= mem[raddr];
			end
			hit_q  <= we_s3 && (pix_s3.idx == pix_s1.idx);
			fwd_q  <= wdata_s3;
			pix_s2 <= pix_s1;
			pix_s3 <= pix_s2;
			floor_s3 <= floor_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// Newest value wins: the item one stage ahead, then the one that wrote
	// while this entry was being read, then the memory itself.
	always_comb begin
		if (we_s3 && (pix_s3.idx == pix_s2.idx)) begin
			floor_s2 = wdata_s3;
		end else if (hit_q) begin
			floor_s2 = fwd_q;
		end else begin
			floor_s2 = rd_s2;
		end
	end

	assign learn_hit = (floor_s3 == '0) || (floor_s3 > pix_s3.depth);
	assign near_hit  = (pix_s3.depth < floor_s3) || (floor_s3 == far_value);

	always_comb begin
		we_s3     = 1'b0;
		wdata_s3  = pix_s3.depth - {{(DEPTH_W-MARGIN_W){1'b0}}, learn_margin};
		cooked_s3 = '0;
		case (pix_s3.action)
			ACT_COOK: begin
				if (near_hit) begin
					cooked_s3 = pix_s3.depth;
				end
			end
			ACT_LEARN: begin
				we_s3 = learn_hit;
			end
			ACT_CLEAR: begin
				we_s3    = 1'b1;
				wdata_s3 = far_value;
			end
			default: begin
			end
		endcase
		if (!(v_s3 && pix_s3.in_range)) begin
			we_s3     = 1'b0;
			cooked_s3 = '0;
		end
	end

	assign res_s3.depth_out    = pix_s3.depth;
	assign res_s3.cooked_depth = cooked_s3;

endmodule

// ===== src/depth_floor_background_subtract.sv =====
// Top level of the depth floor background subtraction block: stream ports,
// configuration registers and the output register. Depends on dfbs_pkg,
// dfbs_front and dfbs_floor.
`timescale 1ns / 1ps

// Takes one depth pixel per clock while the output is not stalled and returns
// one result per pixel, in order. A transaction passes stages s1, s2 and s3
// before the output register, and a new one can be taken every cycle unless
// the output stalls; the rate is set by the single read-modify-write of the
// floor memory, which has one read and one write port and forwards writes
// still in flight to later pixels at the same index. The floor memory holds
// IMAGE_WIDTH * IMAGE_HEIGHT entries with no reset and no clearing pass:
// software must send a clear for every pixel before it learns or cooks. Change
// the far value or learn_margin only while no transaction is in the pipeline.
module depth_floor_background_subtract #(
	parameter int unsigned IMAGE_WIDTH  = 640,
	parameter int unsigned IMAGE_HEIGHT = 480
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,   // pixel_index[18:0], depth_raw[34:19], zero pad
	input  logic [1:0]  s_axis_tuser,   // action[1:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // depth_out[15:0], cooked_depth[31:16]
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_wdata
);
	import dfbs_pkg::*;

	localparam int unsigned PIXEL_COUNT = IMAGE_WIDTH * IMAGE_HEIGHT;

	logic [DEPTH_W-1:0]  far_value_q;
	logic [MARGIN_W-1:0] learn_margin_q;

	logic    adv;
	logic    v_s1;
	pix_t    pix_s1;
	logic    v_s3;
	result_t res_s3;
	logic    out_valid_q;
	result_t out_q;

	// The whole pipeline moves when the output register is empty or drained.
	assign adv           = !out_valid_q || m_axis_tready;
	assign s_axis_tready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			far_value_q    <= FAR_VALUE_RST;
			learn_margin_q <= LEARN_MARGIN_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_FAR_VALUE:    far_value_q    <= cfg_wdata;
				CFG_LEARN_MARGIN: learn_margin_q <= cfg_wdata[MARGIN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	dfbs_front #(
		.PIXEL_COUNT(PIXEL_COUNT)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.adv         (adv),
		.in_valid    (s_axis_tvalid),
		.in_action   (action_t'(s_axis_tuser)),
		.in_idx      (s_axis_tdata[IDX_W-1:0]),
		.in_depth_raw(s_axis_tdata[IDX_W+DEPTH_W-1:IDX_W]),
		.far_value   (far_value_q),
		.v_s1        (v_s1),
		.pix_s1      (pix_s1)
	);

	dfbs_floor #(
		.PIXEL_COUNT(PIXEL_COUNT)
	) u_floor (
		.clk         (clk),
		.arst_n      (arst_n),
		.adv         (adv),
		.v_s1        (v_s1),
		.pix_s1      (pix_s1),
		.far_value   (far_value_q),
		.learn_margin(learn_margin_q),
		.v_s3        (v_s3),
		.res_s3      (res_s3)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q <= res_s3;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {out_q.cooked_depth, out_q.depth_out};

endmodule

// ===== dv/dfbs_floor_checker.sv =====
// Checker for the depth floor background subtraction block: watches both stream
// channels and the configuration port, predicts every result and compares it.
// Depends on dfbs_pkg.
`timescale 1ns / 1ps

module dfbs_floor_checker #(
	parameter int unsigned IMAGE_WIDTH  = 640,
	parameter int unsigned IMAGE_HEIGHT = 480
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,   // pixel_index[18:0], depth_raw[34:19], zero pad
	input  logic [1:0]  s_axis_tuser,   // action[1:0]
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [31:0] m_axis_tdata,   // depth_out[15:0], cooked_depth[31:16]
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_wdata,
	input  logic        end_of_test,
	output int          fail_count,
	output int          pending_count
);
	import dfbs_pkg::*;

	localparam int unsigned PIXEL_COUNT = IMAGE_WIDTH * IMAGE_HEIGHT;

	logic [DEPTH_W-1:0]  far_value;
	logic [MARGIN_W-1:0] learn_margin;
	logic [DEPTH_W-1:0]  floor_level [int unsigned];
	result_t             pending_results [$];
	bit                  leftovers_reported;

	// Applies one pixel to the floor image and returns the result it must produce.
	function automatic result_t subtract_floor(logic [ACT_W-1:0] action,
			logic [IDX_W-1:0] idx, logic [DEPTH_W-1:0] raw);
		result_t            res;
		logic [DEPTH_W-1:0] depth;
		logic [DEPTH_W-1:0] level;
		depth = (raw == '0) ? far_value : raw;
		res.depth_out = depth;
		res.cooked_depth = '0;
		if (idx < PIXEL_COUNT) begin
			level = floor_level.exists(idx) ? floor_level[idx] : '0;
			case (action)
				ACT_COOK: begin
					if (depth < level || level == far_value)
						res.cooked_depth = depth;
				end
				ACT_LEARN: begin
					// The subtraction wraps at 16 bits when the depth is below the margin.
					if (level == '0 || level > depth)
						floor_level[idx] = depth - DEPTH_W'(learn_margin);
				end
				ACT_CLEAR: begin
					floor_level[idx] = far_value;
				end
				default: begin
				end
			endcase
		end
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t got;
		result_t want;
		if (!arst_n) begin
			far_value = FAR_VALUE_RST;
			learn_margin = LEARN_MARGIN_RST;
			floor_level.delete();
			pending_results.delete();
			fail_count = 0;
			pending_count = 0;
			leftovers_reported = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got = m_axis_tdata;
				if (pending_results.size() == 0) begin
					$display("%0t: result depth_out=%0d cooked_depth=%0d with no pixel outstanding",
						$time, got.depth_out, got.cooked_depth);
					fail_count++;
				end else begin
					want = pending_results.pop_front();
					if (got.depth_out !== want.depth_out) begin
						$display("%0t: depth_out expected %0d actual %0d",
							$time, want.depth_out, got.depth_out);
						fail_count++;
					end
					if (got.cooked_depth !== want.cooked_depth) begin
						$display("%0t: cooked_depth expected %0d actual %0d",
							$time, want.cooked_depth, got.cooked_depth);
						fail_count++;
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				pending_results.push_back(subtract_floor(s_axis_tuser,
					s_axis_tdata[IDX_W-1:0], s_axis_tdata[IDX_W +: DEPTH_W]));
			if (cfg_we) begin
				if (cfg_index == CFG_FAR_VALUE)
					far_value = cfg_wdata;
				else
					learn_margin = cfg_wdata[MARGIN_W-1:0];
			end
			if (end_of_test && !leftovers_reported) begin
				leftovers_reported = 1;
				if (pending_results.size() != 0) begin
					$display("%0t: %0d expected results never arrived",
						$time, pending_results.size());
					fail_count += pending_results.size();
				end
			end
			pending_count = pending_results.size();
		end
	end

endmodule

// ===== dv/depth_floor_background_subtract_tb.sv =====
// Testbench top for depth_floor_background_subtract: drives pixels, configuration
// and output back-pressure, and reports the verdict from dfbs_floor_checker.
// Depends on dfbs_pkg, the block under src and dv/dfbs_floor_checker.sv.
`timescale 1ns / 1ps

module depth_floor_background_subtract_tb;
	import dfbs_pkg::*;

	localparam int unsigned IMAGE_WIDTH  = 640;
	localparam int unsigned IMAGE_HEIGHT = 480;
	localparam int unsigned PIXEL_COUNT  = IMAGE_WIDTH * IMAGE_HEIGHT;
	localparam int unsigned IDX_MAX      = (1 << IDX_W) - 1;
	localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;
	localparam int PHASE_ITEMS    = 300;
	localparam int RX_HOLD_CYCLES = 400;
	localparam int LATENCY_TAIL   = 10;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata;
	logic [1:0]  s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [31:0] m_axis_tdata;
	logic        cfg_we;
	logic        cfg_index;
	logic [15:0] cfg_wdata;
	logic        end_of_test;
	logic        hold_request;
	int          fail_count;
	int          pending_count;

	logic [DEPTH_W-1:0] cur_far;
	int                 burst_left;
	int unsigned        cleared_list [$];
	bit                 cleared_pixel [int unsigned];

	depth_floor_background_subtract #(
		.IMAGE_WIDTH  (IMAGE_WIDTH),
		.IMAGE_HEIGHT (IMAGE_HEIGHT)
	) u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata)
	);

	dfbs_floor_checker #(
		.IMAGE_WIDTH  (IMAGE_WIDTH),
		.IMAGE_HEIGHT (IMAGE_HEIGHT)
	) u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.end_of_test   (end_of_test),
		.fail_count    (fail_count),
		.pending_count (pending_count)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("TB_ERROR");
		$finish;
	end

	// Output back-pressure: stretches of different stall patterns, plus one long
	// hold-off on request so the pipeline fills and stalls its input.
	initial begin : rx_pattern
		int mode;
		int span;
		int tick;
		bit hold_taken;
		m_axis_tready = 1'b0;
		hold_taken = 0;
		tick = 0;
		@(posedge arst_n);
		forever begin
			mode = $urandom_range(0, 3);
			span = $urandom_range(16, 160);
			repeat (span) begin
				@(negedge clk);
				tick++;
				if (hold_request && !hold_taken) begin
					hold_taken = 1;
					m_axis_tready = 1'b0;
					repeat (RX_HOLD_CYCLES) @(negedge clk);
				end
				case (mode)
					0: m_axis_tready = 1'b1;
					1: m_axis_tready = ($urandom_range(0, 9) < 7);
					2: m_axis_tready = ($urandom_range(0, 3) == 0);
					default: m_axis_tready = (tick % 3 == 0);
				endcase
			end
		end
	end

	// Sends one pixel, leaving tvalid high afterwards so bursts run back to back.
	task automatic send_pixel(input logic [ACT_W-1:0] action, input int unsigned idx,
			input logic [DEPTH_W-1:0] raw);
		int gap;
		@(negedge clk);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
			if (gap > 0) begin
				s_axis_tvalid = 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		s_axis_tvalid = 1'b1;
		s_axis_tuser = action;
		s_axis_tdata = {5'b0, raw, IDX_W'(idx)};
		do @(posedge clk); while (!s_axis_tready);
		if (action == ACT_CLEAR && idx < PIXEL_COUNT && !cleared_pixel.exists(idx)) begin
			cleared_pixel[idx] = 1;
			cleared_list.push_back(idx);
		end
	endtask

	// Lets every outstanding transaction come out, then idles for a short tail.
	task automatic wait_idle();
		@(negedge clk);
		s_axis_tvalid = 1'b0;
		while (pending_count != 0) @(negedge clk);
		repeat (LATENCY_TAIL) @(negedge clk);
	endtask

	task automatic write_register(input logic index, input logic [15:0] value);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = index;
		cfg_wdata = value;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// Depths cluster around the far value so that cook and learn decisions go
	// both ways; zero and full scale show up regularly.
	function automatic logic [DEPTH_W-1:0] pick_depth();
		int v;
		case ($urandom_range(0, 9))
			0: return '0;
			1: return 16'hFFFF;
			2, 3: return DEPTH_W'($urandom_range(0, 65535));
			default: begin
				v = int'(cur_far) + int'($urandom_range(0, 3000)) - 1500;
				if (v < 1)
					v = 1;
				if (v > 65535)
					v = 65535;
				return DEPTH_W'(v);
			end
		endcase
	endfunction

	// In-range cook and learn only touch pixels that have been cleared, since
	// the floor memory holds garbage until then.
	task automatic random_pixel();
		int unsigned r;
		int unsigned idx;
		r = $urandom_range(0, 99);
		if (r < 5) begin
			send_pixel(ACT_UNUSED, $urandom_range(0, IDX_MAX), pick_depth());
		end else if (r < 10) begin
			send_pixel(ACT_W'($urandom_range(0, 3)), $urandom_range(PIXEL_COUNT, IDX_MAX),
				pick_depth());
		end else if (r < 18) begin
			idx = ($urandom_range(0, 1) == 0) ? $urandom_range(0, PIXEL_COUNT - 1)
				: cleared_list[$urandom_range(0, cleared_list.size() - 1)];
			send_pixel(ACT_CLEAR, idx, pick_depth());
		end else begin
			idx = cleared_list[$urandom_range(0, cleared_list.size() - 1)];
			send_pixel((r < 70) ? ACT_COOK : ACT_LEARN, idx, pick_depth());
		end
	endtask

	initial begin : stimulus
		logic [DEPTH_W-1:0]  far_setting [6];
		logic [MARGIN_W-1:0] margin_setting [6];
		far_setting = '{16'd10000, 16'd0, 16'hFFFF, 16'd1, 16'd30000, 16'd0};
		margin_setting = '{10'd50, 10'd0, 10'd1023, 10'd1023, 10'd0, 10'd0};
		far_setting[5] = DEPTH_W'($urandom_range(0, 65535));
		margin_setting[5] = MARGIN_W'($urandom_range(0, 1023));
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		cfg_we = 1'b0;
		cfg_index = 1'b0;
		cfg_wdata = '0;
		end_of_test = 1'b0;
		hold_request = 1'b0;
		burst_left = 0;
		cur_far = FAR_VALUE_RST;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		// Directed pixels under the reset values of the registers.
		send_pixel(ACT_CLEAR, 0, 16'd0);
		send_pixel(ACT_CLEAR, PIXEL_COUNT - 1, 16'hFFFF);
		send_pixel(ACT_CLEAR, 1, 16'd1234);
		send_pixel(ACT_COOK, 0, 16'd0);
		send_pixel(ACT_COOK, 0, 16'hFFFF);
		send_pixel(ACT_LEARN, 0, 16'd5000);
		send_pixel(ACT_LEARN, 0, 16'd6000);
		send_pixel(ACT_COOK, 0, 16'd4000);
		send_pixel(ACT_COOK, 0, 16'd4950);
		send_pixel(ACT_COOK, 0, 16'd0);
		// Learning a depth below the margin wraps the floor to a large value.
		send_pixel(ACT_LEARN, PIXEL_COUNT - 1, 16'd20);
		send_pixel(ACT_COOK, PIXEL_COUNT - 1, 16'd30000);
		send_pixel(ACT_COOK, PIXEL_COUNT - 1, 16'hFFFF);
		// A floor of zero is always relearned.
		send_pixel(ACT_LEARN, 1, 16'd50);
		send_pixel(ACT_LEARN, 1, 16'd3000);
		send_pixel(ACT_COOK, 1, 16'd2949);
		send_pixel(ACT_COOK, PIXEL_COUNT, 16'd0);
		send_pixel(ACT_LEARN, PIXEL_COUNT, 16'd100);
		send_pixel(ACT_CLEAR, IDX_MAX, 16'hFFFF);
		send_pixel(ACT_COOK, IDX_MAX, 16'd1);
		send_pixel(ACT_UNUSED, 0, 16'd1);
		send_pixel(ACT_UNUSED, IDX_MAX, 16'd0);
		send_pixel(ACT_COOK, 0, 16'd5000);

		// Working set of cleared pixels for the random part.
		send_pixel(ACT_CLEAR, 639, pick_depth());
		send_pixel(ACT_CLEAR, 640, pick_depth());
		repeat (43) send_pixel(ACT_CLEAR, $urandom_range(0, PIXEL_COUNT - 1), pick_depth());

		for (int p = 0; p < 6; p++) begin
			wait_idle();
			if (p % 2 == 0) begin
				write_register(CFG_FAR_VALUE, far_setting[p]);
				write_register(CFG_LEARN_MARGIN, {6'b0, margin_setting[p]});
			end else begin
				write_register(CFG_LEARN_MARGIN, {6'b0, margin_setting[p]});
				write_register(CFG_FAR_VALUE, far_setting[p]);
			end
			cur_far = far_setting[p];
			if (p == 2)
				hold_request = 1'b1;
			repeat (PHASE_ITEMS) random_pixel();
		end

		wait_idle();
		@(negedge clk);
		end_of_test = 1'b1;
		repeat (2) @(negedge clk);
		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// ===== filelist.f =====
src/dfbs_pkg.sv
src/dfbs_front.sv
src/dfbs_floor.sv
src/depth_floor_background_subtract.sv
dv/dfbs_floor_checker.sv
dv/depth_floor_background_subtract_tb.sv
